@@ rtl/csp_pkg.sv @@
// Shared types, codes and register defaults for the color sensor period classifier.
package csp_pkg;

	// Width of the period counters; a count saturates at all ones.
	localparam int COUNT_WIDTH = 16;
	// Width used when a count is compared against a 16-bit threshold.
	localparam int CMP_WIDTH   = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	// Color codes.
	localparam logic [2:0] COLOR_NONE  = 3'd0;
	localparam logic [2:0] COLOR_RED   = 3'd1;
	localparam logic [2:0] COLOR_BLUE  = 3'd2;
	localparam logic [2:0] COLOR_GREEN = 3'd3;
	localparam logic [2:0] COLOR_CLEAR = 3'd4;
	// Marks that no classification has been seen yet in this identification.
	localparam logic [2:0] COLOR_NO_PREV = 3'd7;

	// Indicator lamp codes.
	localparam logic [1:0] IND_OFF   = 2'd0;
	localparam logic [1:0] IND_RED   = 2'd1;
	localparam logic [1:0] IND_GREEN = 2'd2;

	// Filter select codes.
	localparam logic [1:0] FILTER_RED   = 2'd0;
	localparam logic [1:0] FILTER_CLEAR = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] REG_RED_MAX     = 3'd0;
	localparam logic [2:0] REG_CLEAR_MIN   = 3'd1;
	localparam logic [2:0] REG_BLUE_MIN    = 3'd2;
	localparam logic [2:0] REG_GREEN_SPLIT = 3'd3;
	localparam logic [2:0] REG_CLEAR_MAX   = 3'd4;
	localparam logic [2:0] REG_REQ_REPEATS = 3'd5;

	// Register reset values.
	localparam logic [15:0] RST_RED_MAX     = 16'd2000;
	localparam logic [15:0] RST_CLEAR_MIN   = 16'd1500;
	localparam logic [15:0] RST_BLUE_MIN    = 16'd900;
	localparam logic [15:0] RST_GREEN_SPLIT = 16'd3000;
	localparam logic [15:0] RST_CLEAR_MAX   = 16'd2000;
	localparam logic [7:0]  RST_REQ_REPEATS = 8'd3;

	// Current configuration as seen by the datapath.
	typedef struct packed {
		logic [15:0] red_max;
		logic [15:0] clear_min;
		logic [15:0] blue_min;
		logic [15:0] green_split;
		logic [15:0] clear_max;
		logic [7:0]  required_repeats;
	} csp_cfg_t;

	// One input sample.
	typedef struct packed {
		logic pin_level;
		logic start_req;
	} csp_in_t;

	// One result item.
	typedef struct packed {
		logic [1:0] filter_select;
		logic       led_on;
		logic       busy_res;
		logic       color_valid;
		logic [2:0] color;
		logic [1:0] indicator;
		logic       tone_on;
	} csp_out_t;

endpackage

@@ rtl/csp_cfg_regs.sv @@
// Configuration register file for the color sensor period classifier.
module csp_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [2:0]        wr_index,
	input  logic [15:0]       wr_data,
	output csp_pkg::csp_cfg_t cfg
);

	csp_pkg::csp_cfg_t cfg_q;

	// Write decode; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_max          <= csp_pkg::RST_RED_MAX;
			cfg_q.clear_min        <= csp_pkg::RST_CLEAR_MIN;
			cfg_q.blue_min         <= csp_pkg::RST_BLUE_MIN;
			cfg_q.green_split      <= csp_pkg::RST_GREEN_SPLIT;
			cfg_q.clear_max        <= csp_pkg::RST_CLEAR_MAX;
			cfg_q.required_repeats <= csp_pkg::RST_REQ_REPEATS;
		end else if (wr_en) begin
			unique case (wr_index)
				csp_pkg::REG_RED_MAX:     cfg_q.red_max          <= wr_data;
				csp_pkg::REG_CLEAR_MIN:   cfg_q.clear_min        <= wr_data;
				csp_pkg::REG_BLUE_MIN:    cfg_q.blue_min         <= wr_data;
				csp_pkg::REG_GREEN_SPLIT: cfg_q.green_split      <= wr_data;
				csp_pkg::REG_CLEAR_MAX:   cfg_q.clear_max        <= wr_data;
				csp_pkg::REG_REQ_REPEATS: cfg_q.required_repeats <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/csp_classify.sv @@
// Ordered threshold classifier over the four filter counts.
module csp_classify (
	input  csp_pkg::csp_cfg_t cfg,
	input  csp_pkg::count_t   red_cnt,
	input  csp_pkg::count_t   blue_cnt,
	input  csp_pkg::count_t   green_cnt,
	input  csp_pkg::count_t   clear_cnt,
	output logic [2:0]        color
);

	logic [csp_pkg::CMP_WIDTH-1:0] r_w, b_w, g_w, c_w;
	logic [csp_pkg::CMP_WIDTH-1:0] red_max_w, clear_min_w, blue_min_w;
	logic [csp_pkg::CMP_WIDTH-1:0] green_split_w, clear_max_w;

	// Bring counts and thresholds to a common compare width.
	assign r_w           = csp_pkg::CMP_WIDTH'(red_cnt);
	assign b_w           = csp_pkg::CMP_WIDTH'(blue_cnt);
	assign g_w           = csp_pkg::CMP_WIDTH'(green_cnt);
	assign c_w           = csp_pkg::CMP_WIDTH'(clear_cnt);
	assign red_max_w     = csp_pkg::CMP_WIDTH'(cfg.red_max);
	assign clear_min_w   = csp_pkg::CMP_WIDTH'(cfg.clear_min);
	assign blue_min_w    = csp_pkg::CMP_WIDTH'(cfg.blue_min);
	assign green_split_w = csp_pkg::CMP_WIDTH'(cfg.green_split);
	assign clear_max_w   = csp_pkg::CMP_WIDTH'(cfg.clear_max);

	// Tests are taken in priority order; nothing matching gives no color.
	always_comb begin
		if (r_w < red_max_w && c_w > clear_min_w) begin
			color = csp_pkg::COLOR_RED;
		end else if (b_w > blue_min_w && g_w > green_split_w) begin
			color = csp_pkg::COLOR_BLUE;
		end else if (g_w < green_split_w && c_w > clear_min_w) begin
			color = csp_pkg::COLOR_GREEN;
		end else if (c_w < clear_max_w) begin
			color = csp_pkg::COLOR_CLEAR;
		end else begin
			color = csp_pkg::COLOR_NONE;
		end
	end

endmodule

@@ rtl/color_sensor_period_classifier_core.sv @@
// Top level of the color sensor period classifier: sequencer, counters and result register.
//
// Usage: one transfer on the input channel is one timer tick carrying a sample of the
// sensor's frequency pin (pin_level) and a start request (start_req). Every accepted
// sample produces exactly one result transfer on the output channel, showing the filter
// select, LED drive, busy flag, a one-tick color_valid pulse and the last final color
// with its indicator code and tone flag.
// After start, the block steps the filter through red, blue, green and clear, measures
// one pin period per filter (rising edge to second falling edge, saturating count), and
// classifies the four counts. Sweeps repeat until the same color has been seen the
// configured number of further times in a row; then color_valid pulses and busy drops.
// A result is registered in the cycle after its sample is accepted. Throughput:
// one sample per cycle unless the output stalls; the whole update is one pass of logic
// into the result register. Stalls: the result register holds while out_ready is low, and
// in_ready follows out_ready when a result is waiting, so no result is lost or repeated.
// Configuration: the write channel is always ready; write registers only while idle.
// Reset: arst_n clears the sequencer to idle, the final color to none and the
// registers to their defaults; the output channel is empty after reset.
module color_sensor_period_classifier_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  csp_pkg::csp_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output csp_pkg::csp_out_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	typedef enum logic [2:0] {
		PH_WAIT_LOW,
		PH_WAIT_RISE,
		PH_HIGH1,
		PH_LOW1,
		PH_HIGH2
	} phase_t;

	csp_pkg::csp_cfg_t cfg;
	logic              in_fire;

	// Sequencer state.
	phase_t            phase_q, phase_n;
	logic [1:0]        channel_q, channel_n;
	csp_pkg::count_t   tick_q, tick_n, tick_inc;
	csp_pkg::count_t   counts_q [3];
	logic              cnt_wr;
	logic [2:0]        prev_q, prev_n;
	logic [7:0]        rep_q, rep_n;
	logic              active_q, active_n;
	logic [2:0]        final_q, final_n;
	logic              done;
	logic              valid_n;
	logic [2:0]        class_color;

	// Result register.
	logic              out_valid_q;
	csp_pkg::csp_out_t out_q, out_n;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;

	csp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	csp_classify u_classify (
		.cfg       (cfg),
		.red_cnt   (counts_q[0]),
		.blue_cnt  (counts_q[1]),
		.green_cnt (counts_q[2]),
		.clear_cnt (tick_inc),
		.color     (class_color)
	);

	// Saturating tick count while a period is being measured.
	always_comb begin
		tick_inc = tick_q;
		if ((phase_q == PH_HIGH1 || phase_q == PH_LOW1 || phase_q == PH_HIGH2) &&
		    tick_q != {csp_pkg::COUNT_WIDTH{1'b1}}) begin
			tick_inc = tick_q + 1'b1;
		end
	end

	// Next state for one accepted sample.
	always_comb begin
		phase_n   = phase_q;
		channel_n = channel_q;
		tick_n    = tick_q;
		prev_n    = prev_q;
		rep_n     = rep_q;
		active_n  = active_q;
		final_n   = final_q;
		done      = 1'b0;
		valid_n   = 1'b0;
		cnt_wr    = 1'b0;
		if (!active_q) begin
			if (in_data.start_req) begin
				active_n  = 1'b1;
				channel_n = csp_pkg::FILTER_RED;
				phase_n   = PH_WAIT_LOW;
				tick_n    = '0;
				prev_n    = csp_pkg::COLOR_NO_PREV;
				rep_n     = '0;
			end
		end else begin
			tick_n = tick_inc;
			unique case (phase_q)
				PH_WAIT_LOW:  if (!in_data.pin_level) phase_n = PH_WAIT_RISE;
				PH_WAIT_RISE: begin
					if (in_data.pin_level) begin
						phase_n = PH_HIGH1;
						tick_n  = '0;
					end
				end
				PH_HIGH1:     if (!in_data.pin_level) phase_n = PH_LOW1;
				PH_LOW1:      if (in_data.pin_level) phase_n = PH_HIGH2;
				PH_HIGH2:     if (!in_data.pin_level) done = 1'b1;
				default:      phase_n = PH_WAIT_LOW;
			endcase
			if (done) begin
				phase_n = PH_WAIT_LOW;
				tick_n  = '0;
				if (channel_q != csp_pkg::FILTER_CLEAR) begin
					cnt_wr    = 1'b1;
					channel_n = channel_q + 1'b1;
				end else begin
					rep_n  = (class_color == prev_q) ? rep_q + 1'b1 : '0;
					prev_n = class_color;
					if (rep_n == cfg.required_repeats) begin
						final_n  = class_color;
						active_n = 1'b0;
						valid_n  = 1'b1;
					end else begin
						channel_n = csp_pkg::FILTER_RED;
					end
				end
			end
		end
	end

	// Result fields from the updated state.
	always_comb begin
		out_n.filter_select = channel_n;
		out_n.led_on        = active_n;
		out_n.busy_res      = active_n;
		out_n.color_valid   = valid_n;
		out_n.color         = final_n;
		out_n.indicator     = (final_n == csp_pkg::COLOR_RED)   ? csp_pkg::IND_RED   :
		                      (final_n == csp_pkg::COLOR_GREEN) ? csp_pkg::IND_GREEN :
		                                                          csp_pkg::IND_OFF;
		out_n.tone_on       = (final_n == csp_pkg::COLOR_BLUE);
	end

	// Sequencer state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT_LOW;
			channel_q   <= csp_pkg::FILTER_RED;
			tick_q      <= '0;
			prev_q      <= csp_pkg::COLOR_NO_PREV;
			rep_q       <= '0;
			active_q    <= 1'b0;
			final_q     <= csp_pkg::COLOR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				phase_q     <= phase_n;
				channel_q   <= channel_n;
				tick_q      <= tick_n;
				prev_q      <= prev_n;
				rep_q       <= rep_n;
				active_q    <= active_n;
				final_q     <= final_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Per-filter counts and result payload carry no reset.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_q <= out_n;
			if (cnt_wr) begin
				counts_q[channel_q] <= tick_inc;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ rtl/csp_checker.sv @@
// Port-level checker for the color sensor period classifier, bound to the top level.
module csp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input csp_pkg::csp_out_t out_data
);

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// With no result waiting, a new sample can always transfer.
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not ready while result register empty");

	// The LED is driven exactly while busy.
	a_led_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.led_on == out_data.busy_res)
		else $error("LED drive differs from busy flag");

	// A decided color ends the identification.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.color_valid |-> !out_data.busy_res)
		else $error("color decided while still busy");

	// Tone follows the blue decision.
	a_tone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.tone_on == (out_data.color == csp_pkg::COLOR_BLUE))
		else $error("tone flag does not match color");

endmodule

bind color_sensor_period_classifier_core csp_checker u_csp_checker (.*);
